/* sv/round_robin_thread_scheduler_macros.svh */
// Assertion macros for the scheduler
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_MACROS_SVH

// Check that a property holds on every clock edge once reset is released.
`define RRTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, but it also holds while reset is high.
`define RRTS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rrts_pkg.sv */
package rrts_pkg;
  localparam int MaxThreads = 16;
  localparam int IdxW = $clog2(MaxThreads);
  localparam int CntW = $clog2(MaxThreads + 1);

  localparam logic [2:0] REQ_ADD   = 3'd0;
  localparam logic [2:0] REQ_START = 3'd1;
  localparam logic [2:0] REQ_TICK  = 3'd2;
  localparam logic [2:0] REQ_EXIT  = 3'd3;
  localparam logic [2:0] REQ_SLEEP = 3'd4;
  localparam logic [2:0] REQ_WAKE  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_RUNSTATE = 2'd3;
endpackage

/* sv/rrts_ram.sv */
module rrts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/round_robin_thread_scheduler.sv */
// Round-robin thread scheduler. One request is taken at a time, and ready is
// high only while the sequencer is idle. A finished result waits in the output
// register until it is taken, and the next request may be accepted meanwhile;
// a request that finishes while the previous result is still waiting holds
// there until that result is taken. Add, error cases, exit or sleep while
// idle, and ignored codes go from idle straight to the done state. Start and
// tick pass through the pick states, as the pick reads the run list through a
// registered-read memory. Exit and sleep scan the run list entry by entry,
// move the last entry into the freed slot and then pick. Wake checks each
// wait entry in turn and moves each match to the end of the run list, filling
// its wait slot from the last wait entry. The done state returns the sequencer
// to idle once the result is loaded. Lists hold MaxThreads entries each.
module round_robin_thread_scheduler
  import rrts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  valid,
  output logic                  ready,
  input  logic [2:0]            req_type,
  input  logic [7:0]            thread_id,
  input  logic [7:0]            blocker_id,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            status,
  output logic                  switched,
  output logic [7:0]            next_thread,
  output logic                  next_is_idle,
  output logic [4:0]            run_count,
  output logic [4:0]            wait_count,
  output logic [4:0]            woken_count
);
`include "round_robin_thread_scheduler_macros.svh"

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FIND  = 9'b000000010,
    S_FCHK  = 9'b000000100,
    S_MOVE  = 9'b000001000,
    S_PICK  = 9'b000010000,
    S_PICKW = 9'b000100000,
    S_WSCAN = 9'b001000000,
    S_WCHK  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [2:0] req;
  logic [7:0] blk;
  logic [CntW-1:0] run_len, wait_len, woken, scan;
  logic [IdxW-1:0] rr_index, pos;
  logic [7:0] current_id;
  logic current_idle, is_running;
  logic [1:0] st;
  logic sw;
  logic [1:0] step;

  logic run_we, wt_we, wb_we;
  logic [IdxW-1:0] run_wa, run_ra, wait_wa, wait_ra;
  logic [7:0] run_wd, run_rd, wt_wd, wt_rd, wb_wd, wb_rd;

  rrts_ram #(.Width(8), .Depth(MaxThreads)) u_run (
    .clk, .we(run_we), .waddr(run_wa), .wdata(run_wd), .raddr(run_ra), .rdata(run_rd));
  rrts_ram #(.Width(8), .Depth(MaxThreads)) u_wthr (
    .clk, .we(wt_we), .waddr(wait_wa), .wdata(wt_wd), .raddr(wait_ra), .rdata(wt_rd));
  rrts_ram #(.Width(8), .Depth(MaxThreads)) u_wblk (
    .clk, .we(wb_we), .waddr(wait_wa), .wdata(wb_wd), .raddr(wait_ra), .rdata(wb_rd));

  logic [IdxW-1:0] pick_k;
  assign pick_k = ({1'b0, rr_index} < run_len) ? rr_index : '0;

  assign ready = (state == S_IDLE);

  logic load_out;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  logic [IdxW-1:0] last_run, last_wait;
  assign last_run  = IdxW'(run_len - 1'b1);
  assign last_wait = IdxW'(wait_len - 1'b1);

  logic lens_ok;
  assign lens_ok = (run_len <= CntW'(MaxThreads)) && (wait_len <= CntW'(MaxThreads));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      run_len <= '0;
      wait_len <= '0;
      rr_index <= '0;
      current_id <= '0;
      current_idle <= 1'b1;
      is_running <= 1'b0;
      run_we <= 1'b0;
      wt_we <= 1'b0;
      wb_we <= 1'b0;
    end else begin
      run_we <= 1'b0;
      wt_we <= 1'b0;
      wb_we <= 1'b0;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (valid && ready) begin
            req <= req_type;
            blk <= blocker_id;
            st <= ST_OK;
            sw <= 1'b0;
            woken <= '0;
            scan <= '0;
            step <= '0;
            state <= S_DONE;
            priority case (req_type)
              REQ_ADD: begin
                if (run_len >= CntW'(MaxThreads)) begin
                  st <= ST_FULL;
                end else begin
                  run_we <= 1'b1;
                  run_wa <= IdxW'(run_len);
                  run_wd <= thread_id;
                  run_len <= run_len + 1'b1;
                end
              end
              REQ_START: begin
                if (is_running) st <= ST_RUNSTATE;
                else begin
                  is_running <= 1'b1;
                  state <= S_PICK;
                end
              end
              REQ_TICK: begin
                if (!is_running) st <= ST_RUNSTATE;
                else state <= S_PICK;
              end
              REQ_EXIT, REQ_SLEEP: begin
                if (!is_running) st <= ST_RUNSTATE;
                else if (current_idle) st <= ST_NOTFOUND;
                else begin
                  run_ra <= '0;
                  state <= S_FIND;
                end
              end
              REQ_WAKE: begin
                wait_ra <= '0;
                state <= S_WSCAN;
              end
              default: ;
            endcase
          end
        end
        S_FIND: begin
          // read of run_list[scan] in flight
          if (scan >= run_len) begin
            st <= ST_NOTFOUND;
            state <= S_DONE;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (run_rd == current_id) begin
            pos <= IdxW'(scan);
            if (req == REQ_SLEEP && wait_len >= CntW'(MaxThreads)) begin
              st <= ST_FULL;
              state <= S_DONE;
            end else begin
              if (req == REQ_SLEEP) begin
                wt_we <= 1'b1;
                wb_we <= 1'b1;
                wait_wa <= IdxW'(wait_len);
                wt_wd <= current_id;
                wb_wd <= blk;
                wait_len <= wait_len + 1'b1;
              end
              run_ra <= last_run;
              step <= '0;
              state <= S_MOVE;
            end
          end else begin
            scan <= scan + 1'b1;
            run_ra <= IdxW'(scan + 1'b1);
            state <= S_FIND;
          end
        end
        S_MOVE: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else begin
            run_we <= 1'b1;
            run_wa <= pos;
            run_wd <= run_rd;
            run_len <= run_len - 1'b1;
            if (run_len > CntW'(1)) begin
              if ({1'b0, pos} + 1'b1 < run_len - 1'b1) begin
                rr_index <= pos + 1'b1;
              end else if ({1'b0, pos} + 1'b1 == run_len - 1'b1 || run_len == CntW'(2)) begin
                rr_index <= '0;
              end else begin
                rr_index <= IdxW'(1);
              end
            end else begin
              rr_index <= '0;
            end
            state <= S_PICK;
          end
        end
        S_PICK: begin
          run_ra <= pick_k;
          state <= S_PICKW;
          step <= '0;
        end
        S_PICKW: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else begin
            sw <= 1'b1;
            if (run_len != '0) begin
              current_id <= run_rd;
              current_idle <= 1'b0;
              rr_index <= ({1'b0, pick_k} + 1'b1 >= run_len) ? '0 : pick_k + 1'b1;
            end else begin
              current_id <= '0;
              current_idle <= 1'b1;
              rr_index <= '0;
            end
            state <= S_DONE;
          end
        end
        S_WSCAN: begin
          if (scan >= wait_len) state <= S_DONE;
          else begin
            step <= '0;
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (step == 2'd0) begin
            step <= 2'd1;
          end else if (step == 2'd1) begin
            if (wb_rd != blk) begin
              scan <= scan + 1'b1;
              wait_ra <= IdxW'(scan + 1'b1);
              state <= S_WSCAN;
            end else if (run_len >= CntW'(MaxThreads)) begin
              st <= ST_FULL;
              state <= S_DONE;
            end else begin
              run_we <= 1'b1;
              run_wa <= IdxW'(run_len);
              run_wd <= wt_rd;
              run_len <= run_len + 1'b1;
              woken <= woken + 1'b1;
              wait_ra <= last_wait;
              step <= 2'd2;
            end
          end else if (step == 2'd2) begin
            step <= 2'd3;
          end else begin
            wt_we <= 1'b1;
            wb_we <= 1'b1;
            wait_wa <= IdxW'(scan);
            wt_wd <= wt_rd;
            wb_wd <= wb_rd;
            wait_len <= wait_len - 1'b1;
            wait_ra <= IdxW'(scan);
            state <= S_WSCAN;
          end
        end
        S_DONE: begin
          if (load_out) begin
            status <= st;
            switched <= sw;
            next_thread <= current_idle ? 8'd0 : current_id;
            next_is_idle <= current_idle;
            run_count <= 5'(run_len);
            wait_count <= 5'(wait_len);
            woken_count <= 5'(woken);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RRTS_ASSERT(a_len_range, lens_ok, "list length out of range")
  `RRTS_ASSERT(a_idle_id, current_idle |-> (current_id == 8'd0), "idle thread with nonzero id")
  `RRTS_ASSERT(a_busy, (state != S_IDLE) |-> !ready, "ready while busy")
  `RRTS_ASSERT(a_onehot, $onehot(state), "state not one-hot")
  `RRTS_ASSERT_ALWAYS(a_reset, rst |=> ((state == S_IDLE) && !out_valid), "reset not idle")
endmodule

/* verif/testbench.sv */
module testbench;
  import rrts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REQ_NOP6 = 3'd6;
  localparam logic [2:0] REQ_NOP7 = 3'd7;
  localparam int WatchdogLimit = 4000;
  localparam int ExpDepth = 16;
  localparam int DirRows = 19;

  typedef struct packed {
    logic [1:0] status;
    logic       switched;
    logic [7:0] next_thread;
    logic       next_is_idle;
    logic [4:0] run_count;
    logic [4:0] wait_count;
    logic [4:0] woken_count;
  } sched_result_t;

  typedef struct {
    logic [2:0]    req;
    logic [7:0]    tid;
    logic [7:0]    blk;
    bit            has_exp;
    sched_result_t exp;
  } stim_row_t;

  logic clk, rst;
  logic valid, ready, out_valid, out_ready;
  logic [2:0] req_type;
  logic [7:0] thread_id, blocker_id;
  logic [1:0] status;
  logic switched, next_is_idle;
  logic [7:0] next_thread;
  logic [4:0] run_count, wait_count, woken_count;

  round_robin_thread_scheduler DUT (.*);

  // scheduler shadow state
  logic [7:0] run_ids [MaxThreads];
  int         run_n, rr_pos;
  logic [7:0] wait_ids [MaxThreads];
  logic [7:0] wait_blks [MaxThreads];
  int         wait_n;
  logic [7:0] cur_id;
  bit         cur_idle, running;

  sched_result_t expected_results [ExpDepth];
  int  exp_wr = 0;
  int  exp_rd = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  bit  drv_done = 0;
  bit  no_stall = 0;
  int  sent = 0;

  function automatic void reset_model();
    run_n = 0; rr_pos = 0; wait_n = 0;
    cur_id = 0; cur_idle = 1; running = 0;
  endfunction

  function automatic void choose_next();
    int k;
    if (run_n > 0) begin
      k = (rr_pos < run_n) ? rr_pos : 0;
      cur_id = run_ids[k];
      cur_idle = 0;
      rr_pos = (k + 1) % run_n;
    end else begin
      cur_id = 0;
      cur_idle = 1;
      rr_pos = 0;
    end
  endfunction

  function automatic sched_result_t schedule(logic [2:0] req, logic [7:0] tid,
                                             logic [7:0] blk);
    sched_result_t r;
    int pos, i, woken;
    r = '0;
    woken = 0;
    case (req)
      REQ_ADD: begin
        if (run_n >= MaxThreads) r.status = ST_FULL;
        else begin
          run_ids[run_n] = tid;
          run_n++;
        end
      end
      REQ_START: begin
        if (running) r.status = ST_RUNSTATE;
        else begin
          running = 1;
          choose_next();
          r.switched = 1;
        end
      end
      REQ_TICK: begin
        if (!running) r.status = ST_RUNSTATE;
        else begin
          choose_next();
          r.switched = 1;
        end
      end
      REQ_EXIT, REQ_SLEEP: begin
        pos = -1;
        if (!running) r.status = ST_RUNSTATE;
        else begin
          if (!cur_idle)
            for (i = run_n - 1; i >= 0; i--)
              if (run_ids[i] == cur_id) pos = i;
          if (pos < 0) r.status = ST_NOTFOUND;
          else if (req == REQ_SLEEP && wait_n >= MaxThreads) r.status = ST_FULL;
          else begin
            if (req == REQ_SLEEP) begin
              wait_ids[wait_n] = cur_id;
              wait_blks[wait_n] = blk;
              wait_n++;
            end
            run_ids[pos] = run_ids[run_n - 1];
            run_n--;
            rr_pos = (run_n > 0) ? (pos + 1) % run_n : 0;
            choose_next();
            r.switched = 1;
          end
        end
      end
      REQ_WAKE: begin
        i = 0;
        while (i < wait_n) begin
          if (wait_blks[i] != blk) i++;
          else if (run_n >= MaxThreads) begin
            r.status = ST_FULL;
            break;
          end else begin
            run_ids[run_n] = wait_ids[i];
            run_n++;
            wait_ids[i] = wait_ids[wait_n - 1];
            wait_blks[i] = wait_blks[wait_n - 1];
            wait_n--;
            woken++;
          end
        end
      end
      default: ;
    endcase
    r.next_thread = cur_idle ? 8'd0 : cur_id;
    r.next_is_idle = cur_idle;
    r.run_count = run_n[4:0];
    r.wait_count = wait_n[4:0];
    r.woken_count = woken[4:0];
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic [2:0] req, logic [7:0] tid, logic [7:0] blk,
                              bit has_exp, sched_result_t fixed);
    sched_result_t r;
    int gap;
    if (!no_stall && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      valid <= 0;
      repeat (gap) @(negedge clk);
    end
    req_type <= req;
    thread_id <= tid;
    blocker_id <= blk;
    valid <= 1;
    @(posedge clk);
    while (!ready) @(posedge clk);
    r = schedule(req, tid, blk);
    expected_results[exp_wr % ExpDepth] = has_exp ? fixed : r;
    exp_wr++;
    sent++;
    @(negedge clk);
  endtask

  // one random request: add, start, tick, exit, sleep, wake or an ignored code
  task automatic random_request();
    logic [2:0] req;
    logic [7:0] blk;
    int p;
    p = $urandom_range(0, 99);
    blk = 8'($urandom_range(0, 3));
    if (p < 22) req = REQ_ADD;
    else if (p < 30) req = REQ_START;
    else if (p < 52) req = REQ_TICK;
    else if (p < 64) req = REQ_EXIT;
    else if (p < 80) req = REQ_SLEEP;
    else if (p < 96) req = REQ_WAKE;
    else req = $urandom_range(0, 1) ? REQ_NOP6 : REQ_NOP7;
    if ($urandom_range(0, 9) == 0) blk = 8'($urandom_range(0, 255));
    send_request(req, 8'($urandom_range(0, 255)), blk, 0, '0);
  endtask

  stim_row_t dir_rows [DirRows];

  function automatic sched_result_t mk(logic [1:0] st, logic sw, logic [7:0] nt,
                                       logic idle, int rc, int wc, int wk);
    sched_result_t r;
    r = '{st, sw, nt, idle, rc[4:0], wc[4:0], wk[4:0]};
    return r;
  endfunction

  initial begin
    stim_row_t row;
    rst = 1;
    valid = 0;
    out_ready = 0;
    req_type = 0;
    thread_id = 0;
    blocker_id = 0;
    reset_model();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    dir_rows[0] = '{REQ_TICK, 8'h00, 8'h00, 1, mk(ST_RUNSTATE, 0, 0, 1, 0, 0, 0)};
    dir_rows[1] = '{REQ_EXIT, 8'h00, 8'h00, 1, mk(ST_RUNSTATE, 0, 0, 1, 0, 0, 0)};
    dir_rows[2] = '{REQ_SLEEP, 8'h00, 8'hff, 1, mk(ST_RUNSTATE, 0, 0, 1, 0, 0, 0)};
    dir_rows[3] = '{REQ_WAKE, 8'h00, 8'hff, 1, mk(ST_OK, 0, 0, 1, 0, 0, 0)};
    dir_rows[4] = '{REQ_NOP6, 8'hff, 8'hff, 1, mk(ST_OK, 0, 0, 1, 0, 0, 0)};
    dir_rows[5] = '{REQ_START, 8'h00, 8'h00, 1, mk(ST_OK, 1, 0, 1, 0, 0, 0)};
    dir_rows[6] = '{REQ_START, 8'h00, 8'h00, 1, mk(ST_RUNSTATE, 0, 0, 1, 0, 0, 0)};
    dir_rows[7] = '{REQ_EXIT, 8'h00, 8'h00, 1, mk(ST_NOTFOUND, 0, 0, 1, 0, 0, 0)};
    dir_rows[8] = '{REQ_ADD, 8'hff, 8'h00, 1, mk(ST_OK, 0, 0, 1, 1, 0, 0)};
    dir_rows[9] = '{REQ_ADD, 8'h00, 8'h00, 1, mk(ST_OK, 0, 0, 1, 2, 0, 0)};
    dir_rows[10] = '{REQ_TICK, 8'h00, 8'h00, 1, mk(ST_OK, 1, 8'hff, 0, 2, 0, 0)};
    dir_rows[11] = '{REQ_TICK, 8'h00, 8'h00, 1, mk(ST_OK, 1, 8'h00, 0, 2, 0, 0)};
    dir_rows[12] = '{REQ_SLEEP, 8'h00, 8'haa, 0, '0};
    dir_rows[13] = '{REQ_SLEEP, 8'h00, 8'h55, 0, '0};
    dir_rows[14] = '{REQ_WAKE, 8'h00, 8'h55, 0, '0};
    dir_rows[15] = '{REQ_WAKE, 8'h00, 8'haa, 0, '0};
    dir_rows[16] = '{REQ_ADD, 8'h0f, 8'h00, 0, '0};
    dir_rows[17] = '{REQ_EXIT, 8'h00, 8'h00, 0, '0};
    dir_rows[18] = '{REQ_NOP7, 8'h5a, 8'ha5, 0, '0};
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_request(row.req, row.tid, row.blk, row.has_exp, row.exp);
    end
    // full run list, full wait list, wake into full run list
    repeat (17) send_request(REQ_ADD, 8'($urandom_range(0, 255)), 0, 0, '0);
    repeat (17) send_request(REQ_SLEEP, 0, 8'h33, 0, '0);
    repeat (17) send_request(REQ_ADD, 8'($urandom_range(0, 255)), 0, 0, '0);
    send_request(REQ_WAKE, 0, 8'h33, 0, '0);
    send_request(REQ_TICK, 0, 0, 0, '0);

    for (int n = 0; n < 1300; n++) begin
      if (n == 1150) no_stall = 1;
      random_request();
    end
    valid <= 0;
    drv_done = 1;
  end

  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ready <= 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
      if (!no_stall) begin
        gap = $urandom_range(1, 15);
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    sched_result_t exp;
    if (!rst) begin
      if ((valid && ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid && out_ready) begin
        if (exp_wr == exp_rd) begin
          $error("result with no request pending");
          errors++;
        end else begin
          exp = expected_results[exp_rd % ExpDepth];
          exp_rd++;
          if (status !== exp.status) begin
            $error("status exp %0d got %0d", exp.status, status); errors++;
          end
          if (switched !== exp.switched) begin
            $error("switched exp %0d got %0d", exp.switched, switched); errors++;
          end
          if (next_thread !== exp.next_thread) begin
            $error("next_thread exp %0d got %0d", exp.next_thread, next_thread);
            errors++;
          end
          if (next_is_idle !== exp.next_is_idle) begin
            $error("next_is_idle exp %0d got %0d", exp.next_is_idle, next_is_idle);
            errors++;
          end
          if (run_count !== exp.run_count) begin
            $error("run_count exp %0d got %0d", exp.run_count, run_count); errors++;
          end
          if (wait_count !== exp.wait_count) begin
            $error("wait_count exp %0d got %0d", exp.wait_count, wait_count); errors++;
          end
          if (woken_count !== exp.woken_count) begin
            $error("woken_count exp %0d got %0d", exp.woken_count, woken_count);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    wait (drv_done);
    while (exp_wr != exp_rd && idle_cycles < WatchdogLimit) @(posedge clk);
    repeat (50) @(posedge clk);
    if (idle_cycles >= WatchdogLimit || exp_wr != exp_rd || errors != 0)
      $display("end of test: mismatches");
    else
      $display("end of test: clean");
    $finish;
  end

  initial begin
    wait (idle_cycles >= WatchdogLimit && !drv_done);
    $error("watchdog: no progress");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

/* round_robin_thread_scheduler.f */
+incdir+sv
sv/rrts_pkg.sv
sv/rrts_ram.sv
sv/round_robin_thread_scheduler.sv
verif/testbench.sv
